// ===== src/tbr_pkg.sv =====
`default_nettype none

package tbr_pkg;

	localparam logic [7:0] HDR_BYTE = 8'h2A;
	localparam logic [7:0] NAME_END = 8'h0D;
	localparam int HDR_COUNT = 4;
	localparam logic [7:0] HDR_SUM = 8'(HDR_COUNT * int'(HDR_BYTE));

	localparam logic [1:0] KIND_NAME  = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_DONE  = 2'd2;
	localparam logic [1:0] KIND_STRAY = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [1:0]  item_kind;
		logic [7:0]  byte_value;
		logic        name_too_long;
		logic [7:0]  block_flag;
		logic [15:0] block_number;
		logic [7:0]  data_length;
		logic [15:0] exec_address;
		logic [15:0] load_address;
		logic [7:0]  received_checksum;
		logic [7:0]  computed_checksum;
		logic        checksum_ok;
	} tbr_result_t;

endpackage

`default_nettype wire

// ===== src/tbr_parse.sv =====
`default_nettype none

module tbr_parse #(
	parameter int NAME_MAX = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 advance,
	input  wire  [7:0]          rx_byte,
	output tbr_pkg::tbr_result_t result
);
	import tbr_pkg::*;

	localparam int NLW = $clog2(NAME_MAX + 1);
	localparam logic [NLW-1:0] NAME_CAP = NLW'(NAME_MAX);

	localparam logic [3:0] ST_HEADER = 4'd0;
	localparam logic [3:0] ST_NAME   = 4'd1;
	localparam logic [3:0] ST_FLAG   = 4'd2;
	localparam logic [3:0] ST_NUMBER = 4'd3;
	localparam logic [3:0] ST_LENGTH = 4'd4;
	localparam logic [3:0] ST_EXEC   = 4'd5;
	localparam logic [3:0] ST_LOAD   = 4'd6;
	localparam logic [3:0] ST_DATA   = 4'd7;
	localparam logic [3:0] ST_CHECK  = 4'd8;

	logic [3:0]     step_q, step_d;
	logic [1:0]     hdr_cnt_q, hdr_cnt_d;
	logic           pend_q, pend_d;
	logic [NLW-1:0] name_len_q, name_len_d;
	logic           name_ovf_q, name_ovf_d;
	logic [7:0]     data_cnt_q, data_cnt_d;
	logic [7:0]     flag_q, flag_d;
	logic [15:0]    number_q, number_d;
	logic [7:0]     length_q, length_d;
	logic [15:0]    exec_q, exec_d;
	logic [15:0]    load_q, load_d;
	logic [7:0]     sum_q, sum_d;
	logic [7:0]     sum_add;

	assign sum_add = sum_q + rx_byte;

	always_comb begin
		step_d     = step_q;
		hdr_cnt_d  = hdr_cnt_q;
		pend_d     = pend_q;
		name_len_d = name_len_q;
		name_ovf_d = name_ovf_q;
		data_cnt_d = data_cnt_q;
		flag_d     = flag_q;
		number_d   = number_q;
		length_d   = length_q;
		exec_d     = exec_q;
		load_d     = load_q;
		sum_d      = sum_q;
		result     = '0;
		unique case (step_q)
			ST_HEADER: begin
				if (rx_byte != HDR_BYTE) begin
					result.valid      = 1'b1;
					result.item_kind  = KIND_STRAY;
					result.byte_value = rx_byte;
				end else if (hdr_cnt_q == 2'(HDR_COUNT - 1)) begin
					hdr_cnt_d  = '0;
					sum_d      = HDR_SUM;
					name_len_d = '0;
					name_ovf_d = 1'b0;
					pend_d     = 1'b0;
					step_d     = ST_NAME;
				end else begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end
			end
			ST_NAME: begin
				sum_d = sum_add;
				if (rx_byte == NAME_END) begin
					name_len_d = '0;
					step_d     = ST_FLAG;
				end else begin
					if (name_len_q < NAME_CAP)
						name_len_d = name_len_q + NLW'(1);
					else
						name_ovf_d = 1'b1;
					result.valid      = 1'b1;
					result.item_kind  = KIND_NAME;
					result.byte_value = rx_byte;
				end
			end
			ST_FLAG: begin
				flag_d = rx_byte;
				sum_d  = sum_add;
				step_d = ST_NUMBER;
			end
			ST_NUMBER: begin
				sum_d  = sum_add;
				pend_d = !pend_q;
				if (!pend_q) begin
					number_d[15:8] = rx_byte;
				end else begin
					number_d[7:0] = rx_byte;
					step_d        = ST_LENGTH;
				end
			end
			ST_LENGTH: begin
				length_d   = rx_byte;
				sum_d      = sum_add;
				data_cnt_d = '0;
				step_d     = ST_EXEC;
			end
			ST_EXEC: begin
				sum_d  = sum_add;
				pend_d = !pend_q;
				if (!pend_q) begin
					exec_d[15:8] = rx_byte;
				end else begin
					exec_d[7:0] = rx_byte;
					step_d      = ST_LOAD;
				end
			end
			ST_LOAD: begin
				sum_d  = sum_add;
				pend_d = !pend_q;
				if (!pend_q) begin
					load_d[15:8] = rx_byte;
				end else begin
					load_d[7:0] = rx_byte;
					data_cnt_d  = '0;
					step_d      = ST_DATA;
				end
			end
			ST_DATA: begin
				sum_d = sum_add;
				if (data_cnt_q == length_q) begin
					data_cnt_d = '0;
					step_d     = ST_CHECK;
				end else begin
					data_cnt_d = data_cnt_q + 8'd1;
				end
				result.valid      = 1'b1;
				result.item_kind  = KIND_DATA;
				result.byte_value = rx_byte;
			end
			ST_CHECK: begin
				result.valid             = 1'b1;
				result.item_kind         = KIND_DONE;
				result.name_too_long     = name_ovf_q;
				result.block_flag        = flag_q;
				result.block_number      = number_q;
				result.data_length       = length_q;
				result.exec_address      = exec_q;
				result.load_address      = load_q;
				result.received_checksum = rx_byte;
				result.computed_checksum = sum_q;
				result.checksum_ok       = (sum_q == rx_byte);
				step_d     = ST_HEADER;
				hdr_cnt_d  = '0;
				name_len_d = '0;
				name_ovf_d = 1'b0;
				pend_d     = 1'b0;
				data_cnt_d = '0;
			end
			default: begin
				step_d    = ST_HEADER;
				hdr_cnt_d = '0;
				pend_d    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_HEADER;
			hdr_cnt_q  <= '0;
			pend_q     <= 1'b0;
			name_len_q <= '0;
			name_ovf_q <= 1'b0;
			data_cnt_q <= '0;
			flag_q     <= '0;
			number_q   <= '0;
			length_q   <= '0;
			exec_q     <= '0;
			load_q     <= '0;
			sum_q      <= '0;
		end else if (advance) begin
			step_q     <= step_d;
			hdr_cnt_q  <= hdr_cnt_d;
			pend_q     <= pend_d;
			name_len_q <= name_len_d;
			name_ovf_q <= name_ovf_d;
			data_cnt_q <= data_cnt_d;
			flag_q     <= flag_d;
			number_q   <= number_d;
			length_q   <= length_d;
			exec_q     <= exec_d;
			load_q     <= load_d;
			sum_q      <= sum_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/tape_block_receiver.sv =====
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     rx_byte
// output    out_valid / out_stall   item_kind, byte_value, block summary fields
//
// One byte per cycle sustained unless a held result is stalled at the output.
// The input register feeds one pass of the field parser into the result register.
// Reset is asynchronous, active low, and leaves the parser expecting a header byte.
// A stalled result holds the input register, whether or not its byte gives a result.

module tape_block_receiver #(
	parameter int NAME_MAX = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  rx_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  item_kind,
	output logic [7:0]  byte_value,
	output logic        name_too_long,
	output logic [7:0]  block_flag,
	output logic [15:0] block_number,
	output logic [7:0]  data_length,
	output logic [15:0] exec_address,
	output logic [15:0] load_address,
	output logic [7:0]  received_checksum,
	output logic [7:0]  computed_checksum,
	output logic        checksum_ok
);
	import tbr_pkg::*;

	logic        in_valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;
	tbr_result_t res;
	tbr_result_t out_q;

	assign advance  = in_valid_s1 && (!out_q.valid || !out_stall);
	assign in_stall = in_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= rx_byte;
	end

	tbr_parse #(
		.NAME_MAX(NAME_MAX)
	) u_parse (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.rx_byte(byte_s1),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else if (advance) begin
			out_q <= res;
		end else if (!out_stall) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid         = out_q.valid;
	assign item_kind         = out_q.item_kind;
	assign byte_value        = out_q.byte_value;
	assign name_too_long     = out_q.name_too_long;
	assign block_flag        = out_q.block_flag;
	assign block_number      = out_q.block_number;
	assign data_length       = out_q.data_length;
	assign exec_address      = out_q.exec_address;
	assign load_address      = out_q.load_address;
	assign received_checksum = out_q.received_checksum;
	assign computed_checksum = out_q.computed_checksum;
	assign checksum_ok       = out_q.checksum_ok;

`ifndef ASSERT_OFF
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> in_valid_s1 && out_valid && out_stall)
		else $error("input stalled without a held transaction");

	a_check_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == KIND_DONE |->
			checksum_ok == (computed_checksum == received_checksum) && byte_value == 8'd0)
		else $error("block summary inconsistent");

	a_summary_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != KIND_DONE |->
			!checksum_ok && !name_too_long && computed_checksum == 8'd0)
		else $error("summary fields set on a byte transaction");
`endif

endmodule

`default_nettype wire

// ===== tb/tape_block_receiver_tb.sv =====
`default_nettype none

module tape_block_receiver_tb;

	import tbr_pkg::*;

	localparam int NAME_CAP = 16;
	localparam int PHASE_BYTES = 320;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTED = 40;

	typedef enum logic [3:0] {
		P_HEADER, P_NAME, P_FLAG, P_NUMBER, P_LENGTH, P_EXEC, P_LOAD, P_DATA, P_CHECK
	} parse_phase_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  item_kind;
	logic [7:0]  byte_value;
	logic        name_too_long;
	logic [7:0]  block_flag;
	logic [15:0] block_number;
	logic [7:0]  data_length;
	logic [15:0] exec_address;
	logic [15:0] load_address;
	logic [7:0]  received_checksum;
	logic [7:0]  computed_checksum;
	logic        checksum_ok;

	tape_block_receiver #(.NAME_MAX(NAME_CAP)) dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.item_kind         (item_kind),
		.byte_value        (byte_value),
		.name_too_long     (name_too_long),
		.block_flag        (block_flag),
		.block_number      (block_number),
		.data_length       (data_length),
		.exec_address      (exec_address),
		.load_address      (load_address),
		.received_checksum (received_checksum),
		.computed_checksum (computed_checksum),
		.checksum_ok       (checksum_ok)
	);

	logic [7:0]  tape_bytes[$];
	tbr_result_t expected_items[$];
	int          bytes_queued = 0;
	logic [7:0]  frame_sum = 8'h00;

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	bit          hold_go = 1'b0;
	logic        long_hold = 1'b0;
	logic        in_took = 1'b0;

	int          errors = 0;
	int          bytes_in = 0;
	int          blocks_done = 0;
	int          sums_good = 0;
	int          strays_seen = 0;
	int          names_long = 0;

	parse_phase_e phase_q = P_HEADER;
	int           hdr_seen = 0;
	bit           hi_pending = 1'b0;
	int           name_cnt = 0;
	bit           name_long = 1'b0;
	logic [7:0]   data_cnt = 8'h00;
	logic [7:0]   flag_q = 8'h00;
	logic [15:0]  number_q = 16'h0000;
	logic [7:0]   length_q = 8'h00;
	logic [15:0]  exec_q = 16'h0000;
	logic [15:0]  load_q = 16'h0000;
	logic [7:0]   sum_q = 8'h00;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("FAIL");
		$finish;
	end

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			flag_error($sformatf("%s got %h, want %h", field, got, want));
	endtask

	function automatic bit load_pair(inout logic [15:0] word, input logic [7:0] b);
		if (hi_pending)
			word[7:0] = b;
		else
			word[15:8] = b;
		hi_pending = !hi_pending;
		return !hi_pending;
	endfunction

	function automatic bit parse_byte(input logic [7:0] b, output tbr_result_t r);
		bit emit;
		r = '0;
		r.valid = 1'b1;
		emit = 1'b0;
		case (phase_q)
			P_HEADER: begin
				if (b != HDR_BYTE) begin
					r.item_kind = KIND_STRAY;
					r.byte_value = b;
					emit = 1'b1;
				end else if (hdr_seen + 1 >= HDR_COUNT) begin
					hdr_seen = 0;
					sum_q = HDR_SUM;
					name_cnt = 0;
					name_long = 1'b0;
					hi_pending = 1'b0;
					phase_q = P_NAME;
				end else begin
					hdr_seen++;
				end
			end
			P_NAME: begin
				sum_q += b;
				if (b == NAME_END) begin
					name_cnt = 0;
					phase_q = P_FLAG;
				end else begin
					if (name_cnt < NAME_CAP)
						name_cnt++;
					else
						name_long = 1'b1;
					r.item_kind = KIND_NAME;
					r.byte_value = b;
					emit = 1'b1;
				end
			end
			P_FLAG: begin
				flag_q = b;
				sum_q += b;
				phase_q = P_NUMBER;
			end
			P_NUMBER: begin
				sum_q += b;
				if (load_pair(number_q, b))
					phase_q = P_LENGTH;
			end
			P_LENGTH: begin
				length_q = b;
				sum_q += b;
				data_cnt = 8'h00;
				phase_q = P_EXEC;
			end
			P_EXEC: begin
				sum_q += b;
				if (load_pair(exec_q, b))
					phase_q = P_LOAD;
			end
			P_LOAD: begin
				sum_q += b;
				if (load_pair(load_q, b)) begin
					data_cnt = 8'h00;
					phase_q = P_DATA;
				end
			end
			P_DATA: begin
				sum_q += b;
				if (data_cnt == length_q) begin
					data_cnt = 8'h00;
					phase_q = P_CHECK;
				end else begin
					data_cnt++;
				end
				r.item_kind = KIND_DATA;
				r.byte_value = b;
				emit = 1'b1;
			end
			P_CHECK: begin
				r.item_kind = KIND_DONE;
				r.name_too_long = name_long;
				r.block_flag = flag_q;
				r.block_number = number_q;
				r.data_length = length_q;
				r.exec_address = exec_q;
				r.load_address = load_q;
				r.received_checksum = b;
				r.computed_checksum = sum_q;
				r.checksum_ok = (sum_q == b);
				emit = 1'b1;
				phase_q = P_HEADER;
				hdr_seen = 0;
				name_cnt = 0;
				name_long = 1'b0;
				hi_pending = 1'b0;
				data_cnt = 8'h00;
			end
			default: begin
				phase_q = P_HEADER;
				hdr_seen = 0;
				hi_pending = 1'b0;
			end
		endcase
		return emit;
	endfunction

	task automatic send(input logic [7:0] b);
		tape_bytes.push_back(b);
		bytes_queued++;
	endtask

	task automatic frame_field(input logic [7:0] b);
		send(b);
		frame_sum += b;
	endtask

	task automatic queue_block(input int force_len);
		int name_len;
		int len;
		logic [7:0] c;
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 4)) send(8'($urandom));
		for (int i = 0; i < HDR_COUNT; i++) begin
			if ($urandom_range(7) == 0)
				send(8'($urandom));
			send(HDR_BYTE);
		end
		frame_sum = HDR_SUM;
		name_len = ($urandom_range(4) == 0) ? $urandom_range(15, 24) : $urandom_range(0, 8);
		repeat (name_len) begin
			do
				c = 8'($urandom);
			while (c == NAME_END);
			frame_field(c);
		end
		frame_field(NAME_END);
		// drop the rest of the frame now and then
		if ($urandom_range(24) == 0)
			return;
		repeat (2) frame_field(8'($urandom));
		if (force_len >= 0)
			len = force_len;
		else
			len = ($urandom_range(49) == 0) ? 255 : $urandom_range(0, 12);
		frame_field(8'($urandom));
		frame_field(8'(len));
		repeat (4) frame_field(8'($urandom));
		repeat (len + 1) frame_field(8'($urandom));
		send(($urandom_range(3) == 0) ? 8'($urandom) : frame_sum);
	endtask

	task automatic drain();
		while (tape_bytes.size() != 0 || in_valid || expected_items.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_took)) begin
			if (tape_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				rx_byte <= tape_bytes.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= long_hold || ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		tbr_result_t r;
		tbr_result_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				bytes_in++;
				if (parse_byte(rx_byte, r))
					expected_items.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (expected_items.size() == 0) begin
					flag_error($sformatf("unexpected transaction, kind %0d", item_kind));
				end else begin
					want = expected_items.pop_front();
					check_field("item_kind", item_kind, want.item_kind);
					check_field("byte_value", byte_value, want.byte_value);
					check_field("name_too_long", name_too_long, want.name_too_long);
					check_field("block_flag", block_flag, want.block_flag);
					check_field("block_number", block_number, want.block_number);
					check_field("data_length", data_length, want.data_length);
					check_field("exec_address", exec_address, want.exec_address);
					check_field("load_address", load_address, want.load_address);
					check_field("received_checksum", received_checksum,
						want.received_checksum);
					check_field("computed_checksum", computed_checksum,
						want.computed_checksum);
					check_field("checksum_ok", checksum_ok, want.checksum_ok);
					if (want.item_kind == KIND_DONE) begin
						blocks_done++;
						sums_good += want.checksum_ok;
						names_long += want.name_too_long;
					end
					if (want.item_kind == KIND_STRAY)
						strays_seen++;
				end
			end
		end
		in_took <= arst_n && in_valid && !in_stall;
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		int send_mix[4] = '{0, 64, 0, 21};
		int stall_mix[4] = '{0, 0, 64, 21};
		int start;
		repeat (4) @(posedge clk);
		#2 arst_n = 1'b1;
		@(posedge clk);

		send(8'h00);
		send(8'hFF);
		send(8'h2B);
		send(HDR_BYTE);
		send(HDR_BYTE);
		send(8'h55);
		send(HDR_BYTE);
		send(HDR_BYTE);
		frame_sum = HDR_SUM;
		frame_field(8'h00);
		frame_field(8'hFF);
		frame_field(8'h41);
		frame_field(NAME_END);
		frame_field(8'hFF);
		frame_field(8'hFF);
		frame_field(8'hFF);
		frame_field(8'h00);
		frame_field(8'h00);
		frame_field(8'h00);
		frame_field(8'hFF);
		frame_field(8'hFF);
		frame_field(8'hA5);
		send(frame_sum);
		drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_mix[p];
			stall_pct = stall_mix[p];
			start = bytes_queued;
			if (p == 3)
				queue_block(255);
			while (bytes_queued - start < PHASE_BYTES)
				queue_block(-1);
			if (p == 0)
				hold_go = 1'b1;
			drain();
		end

		repeat (20) @(posedge clk);
		if (expected_items.size() != 0)
			flag_error($sformatf("%0d expected transactions never arrived",
				expected_items.size()));
		$display("%0d tape bytes accepted, %0d blocks closed (%0d with good checksum, %0d long names)",
			bytes_in, blocks_done, sums_good, names_long);
		$display("%0d stray header bytes, four idle/stall mixes and one long output hold, %0d errors",
			strays_seen, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
